// ===== rtl/core/rgb2lab_pkg.sv =====
// rgb2lab_pkg: widths, fixed-point constants and shared types of the rgb to cie lab converter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rgb2lab_pkg;

   localparam int unsigned CODE_W = 8;
   localparam int unsigned T_W    = 24;
   localparam int unsigned FRAC_W = 24;
   localparam int unsigned F_W    = 17;
   localparam int unsigned L_W    = 15;
   localparam int unsigned AB_W   = 16;

   // knee of the lab transfer curve, 0.008856 in q0.24
   localparam logic [T_W-1:0] KNEE_Q24       = 24'd148579;
   // linear segment 7.787 * t + 16/116, result in q1.16
   localparam logic [18:0]    LIN_SLOPE_Q16  = 19'd510329;
   localparam logic [13:0]    LIN_OFFSET_Q16 = 14'd9039;

   // rgb to xyz matrix with 1/255 and d65 white normalisation folded in
   localparam logic [15:0] MAT_COEF [3][3] = '{
      '{16'd28551, 16'd24753, 16'd12489},
      '{16'd13992, 16'd47053, 16'd4748},
      '{16'd1168,  16'd7203,  16'd57422}
   };

   localparam logic [6:0] L_GAIN      = 7'd116;
   localparam logic [8:0] A_GAIN      = 9'd500;
   localparam logic [8:0] B_GAIN      = 9'd200;
   localparam logic [23:0] L_OFFSET_Q16 = 24'd1048576;

   // load enables of the transfer-curve stages
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } fpipe_en_type;

endpackage

`default_nettype wire

// ===== rtl/core/rgb2lab_cube_rom.sv =====
// rgb2lab_cube_rom: cube-root table with two registered read ports
// depends on rgb2lab_pkg; points are built at elaboration
`timescale 1ns / 1ps
`default_nettype none

module rgb2lab_cube_rom #(
   parameter int unsigned ENTRIES = 1024,
   localparam int unsigned AW = $clog2(ENTRIES + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr_lo,
   input  wire logic [AW-1:0]              rd_addr_hi,
   output logic      [rgb2lab_pkg::F_W-1:0] rd_data_lo,
   output logic      [rgb2lab_pkg::F_W-1:0] rd_data_hi
);
   import rgb2lab_pkg::*;

   // floor(cbrt(idx / ENTRIES) * 2^16), searched bit by bit without a divide
   function automatic logic [F_W-1:0] cube_point(input int unsigned idx);
      logic [79:0]    lim;
      logic [79:0]    cand_cube;
      logic [F_W-1:0] root;
      logic [F_W-1:0] cand;
      lim  = 80'(idx) << 48;
      root = '0;
      for (int b = F_W - 1; b >= 0; b--) begin
         cand      = root | (F_W'(1) << b);
         cand_cube = 80'(cand) * 80'(cand) * 80'(cand) * 80'(ENTRIES);
         if (cand_cube <= lim) begin
            root = cand;
         end
      end
      return root;
   endfunction

   logic [F_W-1:0] rom_tbl [ENTRIES+1];
   logic [F_W-1:0] data_lo_ff;
   logic [F_W-1:0] data_hi_ff;

   for (genvar i = 0; i <= ENTRIES; i++) begin : g_point
      localparam logic [F_W-1:0] POINT = cube_point(i);
      assign rom_tbl[i] = POINT;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_lo_ff <= rom_tbl[rd_addr_lo];
         data_hi_ff <= rom_tbl[rd_addr_hi];
      end
   end

   assign rd_data_lo = data_lo_ff;
   assign rd_data_hi = data_hi_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rgb2lab_lab_f.sv =====
// rgb2lab_lab_f: three-stage lab transfer curve, cube root by table and interpolation
// depends on rgb2lab_pkg and rgb2lab_cube_rom
`timescale 1ns / 1ps
`default_nettype none

module rgb2lab_lab_f #(
   parameter int unsigned ENTRIES = 1024
) (
   input  wire logic                        clock,
   input  wire rgb2lab_pkg::fpipe_en_type   f_en,
   input  wire logic [rgb2lab_pkg::T_W-1:0] t_value,
   output logic      [rgb2lab_pkg::F_W-1:0] f_value
);
   import rgb2lab_pkg::*;

   localparam int unsigned AW = $clog2(ENTRIES + 1);
   localparam int unsigned SW = FRAC_W + AW;

   logic [SW-1:0]       scaled;
   logic [AW-1:0]       idx_lo;
   logic [AW-1:0]       idx_hi;
   logic [37:0]         lin_sum;
   logic [F_W-1:0]      lin_in;

   logic [FRAC_W-1:0]   frac2_ff;
   logic                above2_ff;
   logic [F_W-1:0]      lin2_ff;
   logic [F_W-1:0]      lo2;
   logic [F_W-1:0]      hi2;

   logic [F_W+FRAC_W-1:0] prod3_in;
   logic [F_W+FRAC_W-1:0] prod3_ff;
   logic [F_W-1:0]      lo3_ff;
   logic                above3_ff;
   logic [F_W-1:0]      lin3_ff;

   logic [F_W-1:0]      f4_in;
   logic [F_W-1:0]      f4_ff;

   // table address and linear segment
   always_comb begin
      scaled  = SW'(t_value) * SW'(ENTRIES);
      idx_lo  = scaled[SW-1:FRAC_W];
      idx_hi  = idx_lo + AW'(1);
      lin_sum = 38'(t_value[17:0]) * 38'(LIN_SLOPE_Q16) + 38'd8388608;
      lin_in  = F_W'(lin_sum[37:24]) + F_W'(LIN_OFFSET_Q16);
   end

   rgb2lab_cube_rom #(
      .ENTRIES (ENTRIES)
   ) u_cube_rom (
      .clock      (clock),
      .rd_en      (f_en.s2),
      .rd_addr_lo (idx_lo),
      .rd_addr_hi (idx_hi),
      .rd_data_lo (lo2),
      .rd_data_hi (hi2)
   );

   always_ff @(posedge clock) begin
      if (f_en.s2) begin
         frac2_ff  <= scaled[FRAC_W-1:0];
         above2_ff <= t_value > KNEE_Q24;
         lin2_ff   <= lin_in;
      end
   end

   // interpolation product
   assign prod3_in = (F_W+FRAC_W)'(hi2 - lo2) * (F_W+FRAC_W)'(frac2_ff);

   always_ff @(posedge clock) begin
      if (f_en.s3) begin
         prod3_ff  <= prod3_in;
         lo3_ff    <= lo2;
         above3_ff <= above2_ff;
         lin3_ff   <= lin2_ff;
      end
   end

   assign f4_in = above3_ff ? lo3_ff + prod3_ff[F_W+FRAC_W-1:FRAC_W] : lin3_ff;

   always_ff @(posedge clock) begin
      if (f_en.s4) begin
         f4_ff <= f4_in;
      end
   end

   assign f_value = f4_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rgb_to_cielab_converter.sv =====
// rgb_to_cielab_converter: six-stage pixel pipeline from 8-bit rgb to cie lab (d65) in q8.8
// depends on rgb2lab_pkg and rgb2lab_lab_f
//
//   port group  | dir | handshake           | fields
//   req_        | in  | req_valid/req_stall | red_level, green_level, blue_level (8 b each)
//   rsp_        | out | rsp_valid/rsp_stall | lightness (15 b), green_red, blue_yellow (16 b s)
//
// one item per clock sustained while rsp_stall is low
// stages: matrix, table read, interpolation multiply, curve select, lab gains, round
// the cube-root table read and its interpolation multiply set the stage split
// reset clears only the stage valid bits
// each stage loads when empty or when the next one moves, so bubbles close up
// req_stall is high only with all six stages full and rsp_stall high
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_cielab_converter #(
   parameter int unsigned CUBE_TABLE_ENTRIES = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [rgb2lab_pkg::CODE_W-1:0]      req_red_level,
   input  wire logic [rgb2lab_pkg::CODE_W-1:0]      req_green_level,
   input  wire logic [rgb2lab_pkg::CODE_W-1:0]      req_blue_level,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic        [rgb2lab_pkg::L_W-1:0]       rsp_lightness,
   output logic signed [rgb2lab_pkg::AB_W-1:0]      rsp_green_red,
   output logic signed [rgb2lab_pkg::AB_W-1:0]      rsp_blue_yellow
);
   import rgb2lab_pkg::*;

   function automatic logic signed [AB_W-1:0] round_sat(input logic signed [26:0] v);
      logic signed [27:0] w;
      logic signed [19:0] q;
      w = 28'(v) + 28'sd128;
      q = 20'(w >>> 8);
      if (q > 20'sd32767) begin
         return 16'sh7fff;
      end
      if (q < -20'sd32768) begin
         return 16'sh8000;
      end
      return AB_W'(q);
   endfunction

   logic [6:1]          vld_ff;
   logic [6:1]          vld_in;
   logic [6:1]          stage_en;
   fpipe_en_type        f_en;

   logic [T_W-1:0]      t_in [3];
   logic [T_W-1:0]      t_ff [3];
   logic [F_W-1:0]      f_val [3];

   logic [23:0]         l_prod;
   logic [22:0]         l5_in;
   logic [22:0]         l5_ff;
   logic signed [17:0]  d_xy;
   logic signed [17:0]  d_yz;
   logic signed [26:0]  a5_in;
   logic signed [26:0]  a5_ff;
   logic signed [26:0]  b5_in;
   logic signed [26:0]  b5_ff;

   logic [24:0]         l6_sum;
   logic [L_W-1:0]      light_ff;
   logic signed [AB_W-1:0] green_red_ff;
   logic signed [AB_W-1:0] blue_yellow_ff;

   // stage load enables and valid bits
   always_comb begin
      stage_en[6] = !vld_ff[6] || !rsp_stall;
      for (int k = 5; k >= 1; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      vld_in[1] = stage_en[1] ? req_valid : vld_ff[1];
      for (int k = 2; k <= 6; k++) begin
         vld_in[k] = stage_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !stage_en[1];
   assign f_en      = '{s2: stage_en[2], s3: stage_en[3], s4: stage_en[4]};

   // normalised xyz
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         t_in[ch] = T_W'(26'(MAT_COEF[ch][0]) * 26'(req_red_level)
                       + 26'(MAT_COEF[ch][1]) * 26'(req_green_level)
                       + 26'(MAT_COEF[ch][2]) * 26'(req_blue_level));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         t_ff <= t_in;
      end
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      rgb2lab_lab_f #(
         .ENTRIES (CUBE_TABLE_ENTRIES)
      ) u_lab_f (
         .clock   (clock),
         .f_en    (f_en),
         .t_value (t_ff[ch]),
         .f_value (f_val[ch])
      );
   end

   // lab gains
   always_comb begin
      l_prod = 24'(f_val[1]) * 24'(L_GAIN);
      l5_in  = (l_prod < L_OFFSET_Q16) ? '0 : 23'(l_prod - L_OFFSET_Q16);
      d_xy   = $signed({1'b0, f_val[0]}) - $signed({1'b0, f_val[1]});
      d_yz   = $signed({1'b0, f_val[1]}) - $signed({1'b0, f_val[2]});
      a5_in  = 27'(d_xy) * $signed({18'b0, A_GAIN});
      b5_in  = 27'(d_yz) * $signed({18'b0, B_GAIN});
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         l5_ff <= l5_in;
         a5_ff <= a5_in;
         b5_ff <= b5_in;
      end
   end

   // round to q8.8
   assign l6_sum = 25'(l5_ff) + 25'd128;

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         light_ff       <= l6_sum[L_W+7:8];
         green_red_ff   <= round_sat(a5_ff);
         blue_yellow_ff <= round_sat(b5_ff);
      end
   end

   assign rsp_valid       = vld_ff[6];
   assign rsp_lightness   = light_ff;
   assign rsp_green_red   = green_red_ff;
   assign rsp_blue_yellow = blue_yellow_ff;

`ifndef SYNTHESIS
   a_light_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lightness <= 15'd25600)
      else $error("lightness above 100");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff) && rsp_stall)
      else $error("input stalled with room in the pipeline");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[1])
      else $error("accepted item missing from first stage");

   a_last_moves: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] && !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("item lost between gain and output stages");
`endif

endmodule

`default_nettype wire
